// File: sv/psc_pkg.sv
// Shared types and constants for the postfix stack calculator.
// Request, response, command and status types, plus controller states.
// No dependencies; every other file in this folder imports this package.
`default_nettype none

package psc_pkg;

    localparam int WORD_W      = 32;
    localparam int IDX_W       = 10;
    localparam int DEPTH_OUT_W = 11;

    typedef enum logic [2:0] {
        OP_PUSH        = 3'd0,
        OP_POP         = 3'd1,
        OP_ADD         = 3'd2,
        OP_SUB         = 3'd3,
        OP_MUL         = 3'd4,
        OP_DIV         = 3'd5,
        OP_PEEK_TOP    = 3'd6,
        OP_PEEK_BOTTOM = 3'd7
    } psc_op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_FEW     = 3'd3,
        ST_DIVZERO = 3'd4,
        ST_FULL    = 3'd5
    } psc_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ2,
        S_OPER,
        S_DIV,
        S_RESP
    } psc_state_t;

    typedef enum logic [1:0] {
        RD_TOP,
        RD_SECOND,
        RD_PEEK
    } psc_rd_sel_t;

    typedef struct packed {
        psc_op_t                   req_type;
        logic signed [WORD_W-1:0]  push_value;
        logic [IDX_W-1:0]          peek_index;
    } psc_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  result_value;
        psc_status_t               status;
        logic [DEPTH_OUT_W-1:0]    stack_depth;
    } psc_rsp_t;

    typedef struct packed {
        logic        load_req;
        logic        rd_en;
        psc_rd_sel_t rd_sel;
        logic        cap_top;
        logic        alu_cap;
        logic        div_start;
        logic        div_cap;
        logic        finish;
    } psc_cmd_t;

    typedef struct packed {
        psc_op_t op;
        logic    base_err;
        logic    top_zero;
        logic    div_done;
    } psc_stat_t;

endpackage

`default_nettype wire

// File: sv/psc_div.sv
// Iterative floored signed divider, one quotient bit per cycle.
// Depends on psc_pkg for the word width.
`default_nettype none

module psc_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [psc_pkg::WORD_W-1:0] dividend,
    input  wire logic signed [psc_pkg::WORD_W-1:0] divisor,
    output logic                                   done,
    output logic signed [psc_pkg::WORD_W-1:0]      quotient
);
    import psc_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] rem_reg;
    logic              neg_reg;

    logic [WORD_W-1:0] a_mag;
    logic [WORD_W-1:0] b_mag;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] rem_next;
    logic              qbit;

    assign a_mag = dividend[WORD_W-1] ? WORD_W'(-dividend) : WORD_W'(dividend);
    assign b_mag = divisor[WORD_W-1]  ? WORD_W'(-divisor)  : WORD_W'(divisor);

    assign trial    = {rem_reg, a_reg[WORD_W-1]};
    assign diff     = trial - {1'b0, b_reg};
    assign qbit     = ~diff[WORD_W];
    assign rem_next = qbit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(WORD_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            rem_reg <= '0;
            neg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (run_reg)
        begin
            a_reg   <= {a_reg[WORD_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    // Round towards minus infinity: negate, and step down one more if inexact.
    always_comb
    begin
        if (!neg_reg)
            quotient = a_reg;
        else if (|rem_reg)
            quotient = ~a_reg;
        else
            quotient = -a_reg;
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// File: sv/psc_ctrl.sv
// Controller state machine for the postfix stack calculator.
// Depends on psc_pkg for states, op codes, command and status types.
`default_nettype none

module psc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire psc_pkg::psc_stat_t stat,
    output psc_pkg::psc_cmd_t       cmd,
    output logic                    busy,
    output logic                    done
);
    import psc_pkg::*;

    psc_state_t state_reg;
    psc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_TOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.base_err)
                    state_next = S_RESP;
                else
                begin
                    case (stat.op)
                        OP_PUSH:
                            state_next = S_RESP;
                        OP_POP:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_TOP;
                            state_next = S_RESP;
                        end
                        OP_PEEK_TOP, OP_PEEK_BOTTOM:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_PEEK;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_TOP;
                            state_next = S_READ2;
                        end
                    endcase
                end
            end
            S_READ2:
            begin
                cmd.cap_top = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_SECOND;
                state_next  = S_OPER;
            end
            S_OPER:
            begin
                if (stat.op != OP_DIV)
                begin
                    cmd.alu_cap = 1'b1;
                    state_next  = S_RESP;
                end
                else if (stat.top_zero)
                    state_next = S_RESP;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_cap = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_RESP:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

endmodule

`default_nettype wire

// File: sv/psc_datapath.sv
// Datapath: stack memory, entry count, operand registers, ALU and divider.
// Depends on psc_pkg and instantiates psc_div.
`default_nettype none

module psc_datapath #(
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire psc_pkg::psc_req_t req,
    input  wire psc_pkg::psc_cmd_t cmd,
    output psc_pkg::psc_stat_t     stat,
    output psc_pkg::psc_rsp_t      rsp
);
    import psc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;
    localparam int EW = (CW > DEPTH_OUT_W) ? CW : DEPTH_OUT_W;

    psc_req_t                 req_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic signed [WORD_W-1:0] mem [STACK_DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;
    logic signed [WORD_W-1:0] top_reg;
    logic signed [WORD_W-1:0] res_reg;
    logic signed [WORD_W-1:0] alu_res;
    logic signed [WORD_W-1:0] div_q;
    logic signed [WORD_W-1:0] wr_data;
    logic                     div_done;

    logic [IW-1:0]  cnt_w;
    logic [IW-1:0]  idx_w;
    logic [IW-1:0]  peek_top_w;
    logic [IW-1:0]  rd_addr_w;
    logic [AW-1:0]  rd_addr;
    logic [CW-1:0]  cnt_m2;
    logic [AW-1:0]  wr_addr;
    logic           wr_en;
    logic           is_push;
    logic           is_arith;
    logic           top_zero;
    logic           ok;
    logic [EW-1:0]  cnt_ext;
    psc_status_t    base_status;
    psc_status_t    status;

    assign cnt_w      = IW'(count_reg);
    assign idx_w      = IW'(req_reg.peek_index);
    assign peek_top_w = cnt_w - idx_w - IW'(1);
    assign cnt_m2     = count_reg - CW'(2);
    assign top_zero   = (top_reg == '0);
    assign is_push    = (req_reg.req_type == OP_PUSH);
    assign is_arith   = (req_reg.req_type inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV});

    always_comb
    begin
        case (cmd.rd_sel)
            RD_TOP:
                rd_addr_w = cnt_w - IW'(1);
            RD_SECOND:
                rd_addr_w = cnt_w - IW'(2);
            RD_PEEK:
                rd_addr_w = (req_reg.req_type == OP_PEEK_TOP) ? peek_top_w : idx_w;
            default:
                rd_addr_w = '0;
        endcase
    end

    assign rd_addr = rd_addr_w[AW-1:0];

    // Checks that need only the request and the entry count.
    always_comb
    begin
        base_status = ST_OK;
        case (req_reg.req_type)
            OP_PUSH:
            begin
                if (count_reg == CW'(STACK_DEPTH))
                    base_status = ST_FULL;
            end
            OP_POP:
            begin
                if (count_reg == '0)
                    base_status = ST_EMPTY;
            end
            OP_PEEK_TOP, OP_PEEK_BOTTOM:
            begin
                if (count_reg == '0)
                    base_status = ST_EMPTY;
                else if (idx_w >= cnt_w)
                    base_status = ST_RANGE;
            end
            default:
            begin
                if (count_reg < CW'(2))
                    base_status = ST_FEW;
            end
        endcase
    end

    always_comb
    begin
        if (base_status != ST_OK)
            status = base_status;
        else if (req_reg.req_type == OP_DIV && top_zero)
            status = ST_DIVZERO;
        else
            status = ST_OK;
    end

    assign ok = (status == ST_OK);

    always_comb
    begin
        case (req_reg.req_type)
            OP_ADD:
                alu_res = rd_data_reg + top_reg;
            OP_SUB:
                alu_res = rd_data_reg - top_reg;
            OP_MUL:
                alu_res = rd_data_reg * top_reg;
            default:
                alu_res = '0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ok)
        begin
            if (is_push)
                count_next = count_reg + CW'(1);
            else if (req_reg.req_type == OP_POP || is_arith)
                count_next = count_reg - CW'(1);
        end
    end

    assign wr_en   = cmd.finish && ok && (is_push || is_arith);
    assign wr_addr = is_push ? count_reg[AW-1:0] : cnt_m2[AW-1:0];
    assign wr_data = is_push ? req_reg.push_value : res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.finish)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_reg <= req;
        if (cmd.cap_top)
            top_reg <= rd_data_reg;
        if (cmd.alu_cap)
            res_reg <= alu_res;
        else if (cmd.div_cap)
            res_reg <= div_q;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    psc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_data_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        stat.op       = req_reg.req_type;
        stat.base_err = (base_status != ST_OK);
        stat.top_zero = top_zero;
        stat.div_done = div_done;
    end

    assign cnt_ext = EW'(count_next);

    always_comb
    begin
        rsp.status      = status;
        rsp.stack_depth = cnt_ext[DEPTH_OUT_W-1:0];
        rsp.result_value = '0;
        if (ok)
        begin
            case (req_reg.req_type)
                OP_POP, OP_PEEK_TOP, OP_PEEK_BOTTOM:
                    rsp.result_value = rd_data_reg;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    rsp.result_value = res_reg;
                default:
                    rsp.result_value = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/postfix_stack_calculator_top.sv
// Postfix stack calculator: push, pop, peek and count or index errors go straight from check
// to response; add, subtract, multiply and a zero divisor first read the second operand and
// pass the operate state; divide also runs the 32-step shift-subtract divider. A new request
// is taken only once the block is idle after the result beat. One memory read port costs the
// second operand read. Reset empties the stack at once; store contents stay as they are. The
// receiver cannot stall: each result beat is shown for one cycle with done high.
`default_nettype none

module postfix_stack_calculator_top #(
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire psc_pkg::psc_req_t req,
    output logic                   done,
    output psc_pkg::psc_rsp_t      result
);
    import psc_pkg::*;

    psc_cmd_t  cmd;
    psc_stat_t stat;

    // Controller: sequences checks, memory reads, the ALU or divider and the final write.
    psc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Datapath: holds the stack and entry count, and builds the result beat.
    psc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (result)
    );

    // A result beat only ever closes a request in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat without a request in progress");

    // An accepted request holds the block busy and gives no beat in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not hold the block busy");

    // After a result beat the block is free again.
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result beat");

endmodule

`default_nettype wire
